// ----- hdl/sjf_pkg.sv -----
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types and constants for the shortest-job-first batch scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  // Default parameter values.
  localparam int DEF_MAX_JOBS   = 16;
  localparam int DEF_BURST_BITS = 16;

  // Fixed field widths of the ports.
  localparam int ID_W       = 8;
  localparam int BURST_IN_W = 16;
  localparam int TIME_W     = 22;
  localparam int TOTAL_W    = 28;

  // Saturation limits of the time outputs.
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_TAIL
  } sjf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic pop;
  } sjf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic one_left;
  } sjf_status_t;

endpackage

// ----- hdl/sjf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sjf_ctrl
// Controller: accepts load transactions, then drains the sorted chain.
// ----------------------------------------------------------------------------
module sjf_ctrl import sjf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        last_item,
  input  sjf_status_t status,
  output sjf_cmd_t    cmd,
  output logic        busy
);

  sjf_state_t state;
  sjf_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && last_item) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.one_left) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    busy      = 1'b1;
    cmd.load  = 1'b0;
    cmd.clear = 1'b0;
    cmd.pop   = 1'b0;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.load  = start;
        cmd.clear = start && last_item;
      end
      ST_EMIT: begin
        cmd.pop = 1'b1;
      end
      ST_TAIL: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- hdl/sjf_chain.sv -----
// ----------------------------------------------------------------------------
// sjf_chain
// Sorted insertion chain: each load inserts a job after every stored job
// whose burst is not greater, and each pop shifts the chain toward the head.
// ----------------------------------------------------------------------------
module sjf_chain import sjf_pkg::*; #(
  parameter int MAX_JOBS   = DEF_MAX_JOBS,
  parameter int BURST_BITS = DEF_BURST_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  pop,
  input  logic [ID_W-1:0]       in_id,
  input  logic [BURST_BITS-1:0] in_burst,
  output logic [ID_W-1:0]       head_id,
  output logic [BURST_BITS-1:0] head_burst,
  output logic                  full,
  output logic                  one_left
);

  logic [ID_W-1:0]       cell_id    [MAX_JOBS];
  logic [BURST_BITS-1:0] cell_burst [MAX_JOBS];
  logic [MAX_JOBS-1:0]   cell_valid;
  logic [MAX_JOBS-1:0]   gt;

  assign full       = cell_valid[MAX_JOBS-1];
  assign one_left   = !cell_valid[1];
  assign head_id    = cell_id[0];
  assign head_burst = cell_burst[0];

  genvar i;
  generate
    for (i = 0; i < MAX_JOBS; i++) begin : g_cell
      logic take_new;
      logic take_prev;

      // An empty cell counts as greater, so the new job lands after all equal bursts.
      assign gt[i] = !cell_valid[i] || (cell_burst[i] > in_burst);

      if (i == 0) begin : g_first
        assign take_new  = gt[i];
        assign take_prev = 1'b0;
      end else begin : g_rest
        assign take_new  = gt[i] && !gt[i-1];
        assign take_prev = gt[i] && gt[i-1];
      end

      // Valid bit of this cell.
      always_ff @(posedge clk) begin
        if (rst) begin
          cell_valid[i] <= 1'b0;
        end else if (pop) begin
          if (i == MAX_JOBS - 1) begin
            cell_valid[i] <= 1'b0;
          end else begin
            cell_valid[i] <= cell_valid[(i + 1) % MAX_JOBS];
          end
        end else if (load && !full) begin
          if (take_new) begin
            cell_valid[i] <= 1'b1;
          end else if (take_prev) begin
            cell_valid[i] <= cell_valid[(i + MAX_JOBS - 1) % MAX_JOBS];
          end
        end
      end

      // Payload of this cell.
      always_ff @(posedge clk) begin
        if (pop) begin
          if (i < MAX_JOBS - 1) begin
            cell_id[i]    <= cell_id[(i + 1) % MAX_JOBS];
            cell_burst[i] <= cell_burst[(i + 1) % MAX_JOBS];
          end
        end else if (load && !full) begin
          if (take_new) begin
            cell_id[i]    <= in_id;
            cell_burst[i] <= in_burst;
          end else if (take_prev) begin
            cell_id[i]    <= cell_id[(i + MAX_JOBS - 1) % MAX_JOBS];
            cell_burst[i] <= cell_burst[(i + MAX_JOBS - 1) % MAX_JOBS];
          end
        end
      end
    end
  endgenerate

endmodule

// ----- hdl/sjf_dpath.sv -----
// ----------------------------------------------------------------------------
// sjf_dpath
// Datapath: the sorted chain, the overflow flag, the waiting-time accumulator
// and two result stages that form the running totals.
// ----------------------------------------------------------------------------
module sjf_dpath import sjf_pkg::*; #(
  parameter int MAX_JOBS   = DEF_MAX_JOBS,
  parameter int BURST_BITS = DEF_BURST_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sjf_cmd_t              cmd,
  input  logic [ID_W-1:0]       job_id,
  input  logic [BURST_IN_W-1:0] burst,
  output sjf_status_t           status,
  output logic                  result_valid,
  output logic [ID_W-1:0]       sched_id,
  output logic [BURST_IN_W-1:0] sched_burst,
  output logic [TIME_W-1:0]     wait_time,
  output logic [TIME_W-1:0]     turnaround,
  output logic [TOTAL_W-1:0]    total_wait,
  output logic [TOTAL_W-1:0]    total_turnaround,
  output logic                  dropped,
  output logic                  last_result
);

  // Exact waiting time needs room for MAX_JOBS full bursts.
  localparam int WAIT_W = BURST_BITS + $clog2(MAX_JOBS);
  localparam int SUM_W  = ((WAIT_W > TOTAL_W) ? WAIT_W : TOTAL_W) + 1;

  logic [BURST_BITS-1:0] in_burst;
  logic [ID_W-1:0]       head_id;
  logic [BURST_BITS-1:0] head_burst;
  logic                  full;
  logic                  one_left;
  logic                  overflow;
  logic [WAIT_W-1:0]     wait_acc;
  logic [WAIT_W-1:0]     ta;

  // First result stage.
  logic                  s_valid;
  logic [ID_W-1:0]       s_id;
  logic [BURST_BITS-1:0] s_burst;
  logic [WAIT_W-1:0]     s_wait;
  logic [WAIT_W-1:0]     s_ta;
  logic                  s_dropped;
  logic                  s_last;

  // Saturated running totals.
  logic [TOTAL_W-1:0]    tot_w;
  logic [TOTAL_W-1:0]    tot_t;
  logic [SUM_W-1:0]      sum_w;
  logic [SUM_W-1:0]      sum_t;
  logic [TOTAL_W-1:0]    tot_w_next;
  logic [TOTAL_W-1:0]    tot_t_next;

  assign in_burst        = BURST_BITS'(burst);
  assign status.one_left = one_left;

  sjf_chain #(
    .MAX_JOBS   (MAX_JOBS),
    .BURST_BITS (BURST_BITS)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .load       (cmd.load),
    .pop        (cmd.pop),
    .in_id      (job_id),
    .in_burst   (in_burst),
    .head_id    (head_id),
    .head_burst (head_burst),
    .full       (full),
    .one_left   (one_left)
  );

  // Overflow flag: set by a job that finds the store full, cleared at batch end.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow <= 1'b0;
    end else if (cmd.pop && one_left) begin
      overflow <= 1'b0;
    end else if (cmd.load && full) begin
      overflow <= 1'b1;
    end
  end

  // Waiting time of the next job: running sum of popped bursts.
  assign ta = wait_acc + WAIT_W'(head_burst);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      wait_acc <= '0;
    end else if (cmd.pop) begin
      wait_acc <= ta;
    end
  end

  // First stage captures the popped job and its exact times.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      s_id      <= head_id;
      s_burst   <= head_burst;
      s_wait    <= wait_acc;
      s_ta      <= ta;
      s_dropped <= overflow;
      s_last    <= one_left;
    end
  end

  // Totals saturate; once past the limit they stay there.
  assign sum_w      = SUM_W'(tot_w) + SUM_W'(s_wait);
  assign sum_t      = SUM_W'(tot_t) + SUM_W'(s_ta);
  assign tot_w_next = (sum_w > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_w);
  assign tot_t_next = (sum_t > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_t);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tot_w <= '0;
      tot_t <= '0;
    end else if (s_valid) begin
      tot_w <= tot_w_next;
      tot_t <= tot_t_next;
    end
  end

  // Output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      sched_id         <= s_id;
      sched_burst      <= BURST_IN_W'(s_burst);
      wait_time        <= (s_wait > WAIT_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(s_wait);
      turnaround       <= (s_ta > WAIT_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(s_ta);
      total_wait       <= tot_w_next;
      total_turnaround <= tot_t_next;
      dropped          <= s_dropped;
      last_result      <= s_last;
    end
  end

endmodule

// ----- hdl/sjf_batch_scheduler_top.sv -----
// Loading: one job per cycle; busy stays low between jobs, so jobs may arrive back to back.
// The last job starts the schedule: each pop in the emit state passes the first result stage and
// the output register; then one result per cycle for the N stored jobs, each strobed by result_valid
// for one cycle. Throughput is set by the sorted insertion chain (one insert or one pop per cycle);
// busy is high through the drain and the tail state after it. The receiver cannot stall the results.
// Synchronous reset empties the chain, clears the overflow flag and returns the controller to idle.
// ----------------------------------------------------------------------------
// sjf_batch_scheduler_top
// Non-preemptive shortest-job-first scheduler for one batch of jobs.
// ----------------------------------------------------------------------------
module sjf_batch_scheduler_top import sjf_pkg::*; #(
  parameter int MAX_JOBS   = DEF_MAX_JOBS,
  parameter int BURST_BITS = DEF_BURST_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ID_W-1:0]       job_id,
  input  logic [BURST_IN_W-1:0] burst,
  input  logic                  last_item,
  output logic                  result_valid,
  output logic [ID_W-1:0]       sched_id,
  output logic [BURST_IN_W-1:0] sched_burst,
  output logic [TIME_W-1:0]     wait_time,
  output logic [TIME_W-1:0]     turnaround,
  output logic [TOTAL_W-1:0]    total_wait,
  output logic [TOTAL_W-1:0]    total_turnaround,
  output logic                  dropped,
  output logic                  last_result
);

  sjf_cmd_t    cmd;
  sjf_status_t status;

  // Controller.
  sjf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Datapath.
  sjf_dpath #(
    .MAX_JOBS   (MAX_JOBS),
    .BURST_BITS (BURST_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .job_id           (job_id),
    .burst            (burst),
    .status           (status),
    .result_valid     (result_valid),
    .sched_id         (sched_id),
    .sched_burst      (sched_burst),
    .wait_time        (wait_time),
    .turnaround       (turnaround),
    .total_wait       (total_wait),
    .total_turnaround (total_turnaround),
    .dropped          (dropped),
    .last_result      (last_result)
  );

endmodule

// ----- tb/sjf_schedule_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sjf_schedule_checker
// Watches the job and result channels of the batch scheduler, keeps its own
// copy of the job store, builds the expected shortest-job-first schedule for
// every batch and compares each strobed result with it field by field.
// ----------------------------------------------------------------------------
module sjf_schedule_checker import sjf_pkg::*; #(
  parameter int MAX_JOBS   = DEF_MAX_JOBS,
  parameter int BURST_BITS = DEF_BURST_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [ID_W-1:0]       job_id,
  input  logic [BURST_IN_W-1:0] burst,
  input  logic                  last_item,
  input  logic                  result_valid,
  input  logic [ID_W-1:0]       sched_id,
  input  logic [BURST_IN_W-1:0] sched_burst,
  input  logic [TIME_W-1:0]     wait_time,
  input  logic [TIME_W-1:0]     turnaround,
  input  logic [TOTAL_W-1:0]    total_wait,
  input  logic [TOTAL_W-1:0]    total_turnaround,
  input  logic                  dropped,
  input  logic                  last_result,
  output int unsigned           fail_count,
  output int unsigned           pending,
  output int unsigned           results_seen
);

  // One scheduled job as the block should report it.
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [BURST_IN_W-1:0] burst;
    logic [TIME_W-1:0]     wait_time;
    logic [TIME_W-1:0]     turnaround;
    logic [TOTAL_W-1:0]    total_wait;
    logic [TOTAL_W-1:0]    total_turnaround;
    logic                  dropped;
    logic                  last;
  } sched_slot_t;

  sched_slot_t           schedule_q[$];
  logic [ID_W-1:0]       id_copy [MAX_JOBS];
  logic [BURST_IN_W-1:0] burst_copy [MAX_JOBS];
  int unsigned           stored_jobs = 0;
  logic                  overflowed = 1'b0;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  // Only the low BURST_BITS bits of a burst are kept by the store.
  function automatic logic [BURST_IN_W-1:0] kept_burst(logic [BURST_IN_W-1:0] b);
    longint unsigned mask;
    mask = (64'd1 << BURST_BITS) - 64'd1;
    return b & BURST_IN_W'(mask);
  endfunction

  function automatic longint unsigned saturate(longint unsigned v, longint unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // Orders the stored jobs by ascending burst, keeping arrival order on ties,
  // and queues one expected result per job with its wait and turnaround.
  function automatic void plan_schedule();
    logic [ID_W-1:0]       ids [MAX_JOBS];
    logic [BURST_IN_W-1:0] bursts [MAX_JOBS];
    longint unsigned       run_wait;
    longint unsigned       sum_wait;
    longint unsigned       sum_turn;
    longint unsigned       turn;
    int                    j;
    sched_slot_t           slot;
    run_wait = 0;
    sum_wait = 0;
    sum_turn = 0;
    for (int i = 0; i < int'(stored_jobs); i++) begin
      j = i;
      while (j > 0 && bursts[j-1] > burst_copy[i]) begin
        bursts[j] = bursts[j-1];
        ids[j]    = ids[j-1];
        j--;
      end
      bursts[j] = burst_copy[i];
      ids[j]    = id_copy[i];
    end
    for (int i = 0; i < int'(stored_jobs); i++) begin
      turn     = run_wait + bursts[i];
      sum_wait = sum_wait + run_wait;
      sum_turn = sum_turn + turn;
      slot.id               = ids[i];
      slot.burst            = bursts[i];
      slot.wait_time        = TIME_W'(saturate(run_wait, TIME_MAX));
      slot.turnaround       = TIME_W'(saturate(turn, TIME_MAX));
      slot.total_wait       = TOTAL_W'(saturate(sum_wait, TOTAL_MAX));
      slot.total_turnaround = TOTAL_W'(saturate(sum_turn, TOTAL_MAX));
      slot.dropped          = overflowed;
      slot.last             = (i + 1 == int'(stored_jobs));
      schedule_q.push_back(slot);
      run_wait = turn;
    end
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result transactions are checked before the job transaction of the same
  // edge is taken in; a last job never produces a result on its own edge.
  always @(posedge clk) begin
    sched_slot_t want;
    if (rst) begin
      stored_jobs = 0;
      overflowed  = 1'b0;
      schedule_q.delete();
    end else begin
      if (result_valid) begin
        results_seen++;
        if (schedule_q.size() == 0) begin
          $error("Unexpected result transaction: id %0d burst %0d", sched_id, sched_burst);
          fail_count++;
        end else begin
          want = schedule_q.pop_front();
          compare_field("sched_id", want.id, sched_id);
          compare_field("sched_burst", want.burst, sched_burst);
          compare_field("wait_time", want.wait_time, wait_time);
          compare_field("turnaround", want.turnaround, turnaround);
          compare_field("total_wait", want.total_wait, total_wait);
          compare_field("total_turnaround", want.total_turnaround, total_turnaround);
          compare_field("dropped", want.dropped, dropped);
          compare_field("last_result", want.last, last_result);
        end
      end
      if (start && !busy) begin
        if (stored_jobs < MAX_JOBS) begin
          id_copy[stored_jobs]    = job_id;
          burst_copy[stored_jobs] = kept_burst(burst);
          stored_jobs++;
        end else begin
          overflowed = 1'b1;
        end
        if (last_item) begin
          plan_schedule();
          stored_jobs = 0;
          overflowed  = 1'b0;
        end
      end
    end
    pending = schedule_q.size();
  end

endmodule

// ----- tb/tb_sjf_batch_scheduler_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sjf_batch_scheduler_top
// Drives batches of jobs into the scheduler: a few directed batches for ties,
// extreme fields and store overflow, then random batches with random gaps.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_sjf_batch_scheduler_top;
  import sjf_pkg::*;

  localparam int MAX_JOBS     = DEF_MAX_JOBS;
  localparam int BURST_BITS   = DEF_BURST_BITS;
  localparam int RANDOM_JOBS  = 190;
  localparam int QUIET_CYCLES = MAX_JOBS + 8;
  localparam int DRAIN_LIMIT  = 4000;

  // How the bursts of one random batch are drawn.
  typedef enum int {
    MIX_TIES,
    MIX_EXTREME,
    MIX_WIDE
  } burst_mix_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [ID_W-1:0]       job_id;
  logic [BURST_IN_W-1:0] burst;
  logic                  last_item;
  logic                  result_valid;
  logic [ID_W-1:0]       sched_id;
  logic [BURST_IN_W-1:0] sched_burst;
  logic [TIME_W-1:0]     wait_time;
  logic [TIME_W-1:0]     turnaround;
  logic [TOTAL_W-1:0]    total_wait;
  logic [TOTAL_W-1:0]    total_turnaround;
  logic                  dropped;
  logic                  last_result;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned jobs_sent = 0;
  int unsigned batches_sent = 0;
  int unsigned overflow_batches = 0;

  sjf_batch_scheduler_top #(
    .MAX_JOBS  (MAX_JOBS),
    .BURST_BITS(BURST_BITS)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .job_id          (job_id),
    .burst           (burst),
    .last_item       (last_item),
    .result_valid    (result_valid),
    .sched_id        (sched_id),
    .sched_burst     (sched_burst),
    .wait_time       (wait_time),
    .turnaround      (turnaround),
    .total_wait      (total_wait),
    .total_turnaround(total_turnaround),
    .dropped         (dropped),
    .last_result     (last_result)
  );

  sjf_schedule_checker #(
    .MAX_JOBS  (MAX_JOBS),
    .BURST_BITS(BURST_BITS)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .job_id          (job_id),
    .burst           (burst),
    .last_item       (last_item),
    .result_valid    (result_valid),
    .sched_id        (sched_id),
    .sched_burst     (sched_burst),
    .wait_time       (wait_time),
    .turnaround      (turnaround),
    .total_wait      (total_wait),
    .total_turnaround(total_turnaround),
    .dropped         (dropped),
    .last_result     (last_result),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_seen    (results_seen)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  // Presents one job transaction after an optional idle gap and holds it
  // until the block takes it. Called and returns at a falling edge.
  task automatic send_job(input logic [ID_W-1:0] id, input logic [BURST_IN_W-1:0] b,
                          input logic last, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    job_id    <= id;
    burst     <= b;
    last_item <= last;
    do @(posedge clk); while (busy);
    @(negedge clk);
    jobs_sent++;
  endtask

  function automatic logic [BURST_IN_W-1:0] draw_burst(burst_mix_t mix);
    case (mix)
      MIX_TIES: return BURST_IN_W'($urandom_range(0, 7));
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          default: return BURST_IN_W'($urandom);
        endcase
      end
      default: return BURST_IN_W'($urandom);
    endcase
  endfunction

  // One random batch; a length beyond the store exercises the drop path.
  task automatic send_random_batch();
    int unsigned len;
    burst_mix_t  mix;
    logic        gaps;
    case ($urandom_range(0, 9))
      0: len = 1;
      1: len = MAX_JOBS;
      2: len = MAX_JOBS + $urandom_range(1, 6);
      default: len = $urandom_range(2, MAX_JOBS - 1);
    endcase
    case ($urandom_range(0, 2))
      0: mix = MIX_TIES;
      1: mix = MIX_EXTREME;
      default: mix = MIX_WIDE;
    endcase
    gaps = ($urandom_range(0, 2) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_job(ID_W'($urandom), draw_burst(mix), (i + 1 == len),
               gaps ? $urandom_range(0, 16) : 0);
    end
    batches_sent++;
    if (len > MAX_JOBS) overflow_batches++;
  endtask

  initial begin
    int unsigned directed_jobs;
    int unsigned drain;
    rst       = 1'b1;
    start     = 1'b0;
    job_id    = '0;
    burst     = '0;
    last_item = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-job batch with the smallest fields.
    send_job(8'h00, 16'h0000, 1'b1, 0);
    batches_sent++;

    // Ties must keep arrival order; largest id and burst included.
    send_job(8'hFF, 16'hFFFF, 1'b0, 0);
    send_job(8'hAA, 16'd5, 1'b0, 0);
    send_job(8'h55, 16'd5, 1'b0, 3);
    send_job(8'h01, 16'h0000, 1'b0, 0);
    send_job(8'h80, 16'd5, 1'b1, 0);
    batches_sent++;

    // One job more than the store holds; the dropped one is the last.
    for (int unsigned i = 0; i <= MAX_JOBS; i++) begin
      send_job(ID_W'(i), BURST_IN_W'(16'hFFFF - i * 16'h1111), (i == MAX_JOBS), 0);
    end
    batches_sent++;
    overflow_batches++;
    directed_jobs = jobs_sent;

    while (jobs_sent < directed_jobs + RANDOM_JOBS) send_random_batch();
    start <= 1'b0;

    // Let the last schedule drain, then give the block time to go quiet.
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (QUIET_CYCLES) @(negedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);

    $display("Run covered %0d jobs in %0d batches, %0d of them overflowing the store.",
             jobs_sent, batches_sent, overflow_batches);
    $display("Checked %0d schedule results against the prediction.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
